### hw/rtl/abst_pkg.sv
`default_nettype none

package abst_pkg;

  localparam int unsigned LEVELS = 8;
  localparam int unsigned NODES  = (1 << LEVELS) - 1;
  localparam int unsigned IDX_W  = LEVELS;
  localparam int unsigned KEY_W  = 32;

  // request kinds carried on tuser
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_ROOM   = 2'd3
  } status_e;

  typedef struct packed {
    logic lt;  // probe key below node key
    logic eq;  // probe key equals node key
  } cmp_res_t;

endpackage

`default_nettype wire

### hw/rtl/abst_ram.sv
`default_nettype none

module abst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 255,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/abst_cmp.sv
`default_nettype none

module abst_cmp
  import abst_pkg::*;
(
  input  wire logic signed [KEY_W-1:0] probe_i,
  input  wire logic signed [KEY_W-1:0] node_i,
  output cmp_res_t                     res_o
);

  always_comb begin
    res_o.lt = (probe_i < node_i);
    res_o.eq = (probe_i == node_i);
  end

endmodule

`default_nettype wire

### hw/rtl/array_binary_search_tree_unit.sv
// Binary search tree held in an implicit array of 2^LEVELS-1 nodes (children of node i at
// 2i+1 and 2i+2). Each input word is an insert (tuser 0) or a search (tuser 1) of the signed
// key in tdata; each gives one output word with a status: inserted, found, not found or no
// room on path. Equal keys go right on insert. A request occupies the block from its accept
// cycle through any walk of the tree, level by level (a key memory read feeding the single
// comparator), until its result is handed to the output register, which waits for as long
// as a previous result waits unaccepted on the output.
// s_axis_tready is low while a request walks the tree. The node-occupied flags are cleared
// by reset, so no clearing pass is needed and the block is ready straight after reset.
`default_nettype none

module array_binary_search_tree_unit
  import abst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] key (signed)
  input  wire logic        s_axis_tuser,   // [0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [1:0] status, [7:2] zero
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic [KEY_W-1:0] key_q;
  logic             type_q;
  status_e          res_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [NODES-1:0] used_q;

  logic             accept;
  logic [IDX_W:0]   nxt;
  logic             ovf;
  logic             nxt_used;
  logic [KEY_W-1:0] node_key;
  cmp_res_t         cmp;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic             out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  abst_cmp u_cmp (
    .probe_i (key_q),
    .node_i  (node_key),
    .res_o   (cmp)
  );

  always_comb begin
    nxt      = {idx_q, 1'b0} + (IDX_W+1)'(cmp.lt ? 1 : 2);
    ovf      = (nxt >= (IDX_W+1)'(NODES));
    nxt_used = ovf ? 1'b1 : used_q[nxt[IDX_W-1:0]];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = key_q;
    ram_raddr = '0;
    if (state_q == S_IDLE) begin
      // empty tree: insert lands at the root
      ram_we    = accept && (s_axis_tuser == REQ_INSERT) && !used_q[0];
      ram_wdata = s_axis_tdata;
    end else if (state_q == S_WALK) begin
      ram_waddr = nxt[IDX_W-1:0];
      ram_raddr = ovf ? '0 : nxt[IDX_W-1:0];
      ram_we    = (type_q == REQ_INSERT) && !ovf && !nxt_used;
    end
  end

  abst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (NODES)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (node_key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      type_q       <= REQ_INSERT;
      res_q        <= ST_INSERTED;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_INSERTED;
      used_q       <= '0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            key_q  <= s_axis_tdata;
            type_q <= s_axis_tuser;
            idx_q  <= '0;
            if (used_q[0]) begin
              state_q <= S_WALK;
            end else begin
              if (s_axis_tuser == REQ_INSERT) begin
                used_q[0] <= 1'b1;
                res_q     <= ST_INSERTED;
              end else begin
                res_q <= ST_NOT_FOUND;
              end
              state_q <= S_DONE;
            end
          end
        end
        S_WALK: begin
          if (type_q == REQ_SEARCH && cmp.eq) begin
            res_q   <= ST_FOUND;
            state_q <= S_DONE;
          end else if (ovf) begin
            res_q   <= (type_q == REQ_INSERT) ? ST_NO_ROOM : ST_NOT_FOUND;
            state_q <= S_DONE;
          end else if (!nxt_used) begin
            if (type_q == REQ_INSERT) begin
              used_q[nxt[IDX_W-1:0]] <= 1'b1;
              res_q                  <= ST_INSERTED;
            end else begin
              res_q <= ST_NOT_FOUND;
            end
            state_q <= S_DONE;
          end else begin
            idx_q <= nxt[IDX_W-1:0];
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_status_q <= res_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_status_q};

endmodule

`default_nettype wire

### hw/rtl/abst_checker.sv
`default_nettype none

module abst_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata
);

  // one request at a time: busy straight after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous request in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'd0))
    else $error("result padding not zero");

  // a fresh result is registered only from the done state, so none can appear the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared without a walk");

  // reset seen at an edge leaves no result valid by the next one
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind array_binary_search_tree_unit abst_checker u_abst_checker (.*);

`default_nettype wire

### tb/array_binary_search_tree_unit_test.sv
`timescale 1ns / 100ps

module array_binary_search_tree_unit_test;
  import abst_pkg::*;

  typedef struct packed {
    logic              req;
    logic [KEY_W-1:0]  key;
  } tree_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_req = REQ_INSERT;
  logic [KEY_W-1:0] in_key = '0;
  logic             out_ready = 1'b0;

  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic [7:0] m_axis_tdata;

  array_binary_search_tree_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_key),    // [31:0] key (signed)
    .s_axis_tuser  (in_req),    // [0] req_type
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata)  // [1:0] status, [7:2] zero
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow tree, updated as each word is accepted
  logic signed [KEY_W-1:0] node_key [NODES];
  logic                    node_used [NODES];

  tree_req_t        pending_reqs[$];
  status_e          expected_status[$];
  logic [KEY_W-1:0] sent_keys[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int rx_hold_req = 0;
  int rx_hold_seen = 0;
  int rx_hold_cnt = 0;

  function automatic status_e tree_apply(input logic req, input logic signed [KEY_W-1:0] key);
    int unsigned idx;
    int unsigned nxt;
    idx = 0;
    if (!node_used[0]) begin
      if (req == REQ_SEARCH) return ST_NOT_FOUND;
      node_key[0] = key;
      node_used[0] = 1'b1;
      return ST_INSERTED;
    end
    while (1) begin
      if (req == REQ_SEARCH && node_key[idx] == key) return ST_FOUND;
      nxt = (key < node_key[idx]) ? 2 * idx + 1 : 2 * idx + 2;
      if (nxt >= NODES) return (req == REQ_SEARCH) ? ST_NOT_FOUND : ST_NO_ROOM;
      if (!node_used[nxt]) begin
        if (req == REQ_SEARCH) return ST_NOT_FOUND;
        node_key[nxt] = key;
        node_used[nxt] = 1'b1;
        return ST_INSERTED;
      end
      idx = nxt;
    end
    return ST_NOT_FOUND;
  endfunction

  // driver: a word leaves the queue only once the previous one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      for (int i = 0; i < NODES; i++) node_used[i] = 1'b0;
    end else if (!in_valid || s_axis_tready) begin
      if (in_valid) expected_status.push_back(tree_apply(in_req, in_key));
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_req   <= pending_reqs[0].req;
        in_key   <= pending_reqs[0].key;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_cnt  <= 400;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && out_ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected output word, expected none, got %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          if (m_axis_tdata !== {6'd0, expected_status[0]}) begin
            $display("%0t: status mismatch, expected %h (%s), got %h", $time,
                     {6'd0, expected_status[0]}, expected_status[0].name(), m_axis_tdata);
            mismatches++;
          end
          void'(expected_status.pop_front());
        end
      end
      out_ready <= (rx_hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_req(input logic req, input logic [KEY_W-1:0] key);
    tree_req_t r;
    r.req = req;
    r.key = key;
    pending_reqs.push_back(r);
    if (req == REQ_INSERT) sent_keys.push_back(key);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_status.size() > 0)
      @(negedge clk_i);
  endtask

  task automatic queue_random(input int n);
    logic             req;
    logic [KEY_W-1:0] key;
    int               pick;
    for (int i = 0; i < n; i++) begin
      req  = ($urandom_range(99) < 45) ? REQ_INSERT : REQ_SEARCH;
      pick = $urandom_range(99);
      if (pick < 40 || (pick < 65 && sent_keys.size() == 0)) begin
        key = $urandom();
      end else if (pick < 65) begin
        key = sent_keys[$urandom_range(sent_keys.size() - 1)];
      end else if (pick < 90) begin
        // narrow range: plenty of equal keys and neighbours
        key = $urandom_range(40) - 20;
      end else begin
        case ($urandom_range(3))
          0: key = 32'h8000_0000;
          1: key = 32'h7fff_ffff;
          2: key = 32'h0000_0000;
          default: key = 32'hffff_ffff;
        endcase
      end
      queue_req(req, key);
    end
  endtask

  task automatic run_phase(input int n, input int send_pct, input int recv_pct,
                           input bit hold_off);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(n / 2);
    if (hold_off) rx_hold_req++;
    // sender pauses mid-phase until the pipeline is empty
    wait_drained();
    queue_random(n - n / 2);
    wait_drained();
  endtask

  // insert a key aimed at every empty node whose parent is occupied and whose key range is not empty, level by level
  task automatic fill_tree();
    longint      lo;
    longint      hi;
    int unsigned c;
    int unsigned p;
    int          found;
    for (int pass = 0; pass < LEVELS; pass++) begin
      found = 0;
      for (int unsigned n = 1; n < NODES; n++) begin
        if (!node_used[n] && node_used[(n - 1) / 2]) begin
          lo = -64'sd2147483648;
          hi = 64'sd2147483647;
          c  = n;
          while (c != 0) begin
            p = (c - 1) / 2;
            if (c % 2 == 1) begin
              if (longint'(node_key[p]) - 1 < hi) hi = longint'(node_key[p]) - 1;
            end else begin
              if (longint'(node_key[p]) > lo) lo = longint'(node_key[p]);
            end
            c = p;
          end
          if (lo <= hi) begin
            queue_req(REQ_INSERT,
                      KEY_W'(lo + ((hi - lo) * longint'($urandom_range(768, 256))) / 1024));
            found++;
          end
        end
      end
      wait_drained();
      if (found == 0) break;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty tree, root, duplicates down the right spine until no room, extremes
    queue_req(REQ_SEARCH, 32'd0);
    queue_req(REQ_INSERT, 32'd0);
    queue_req(REQ_SEARCH, 32'd0);
    queue_req(REQ_SEARCH, 32'd5);
    for (int i = 0; i < LEVELS; i++) queue_req(REQ_INSERT, 32'h7fff_ffff);
    queue_req(REQ_SEARCH, 32'h7fff_ffff);
    queue_req(REQ_INSERT, 32'h8000_0000);
    queue_req(REQ_SEARCH, 32'h8000_0000);
    queue_req(REQ_INSERT, 32'hffff_ffff);
    queue_req(REQ_SEARCH, 32'hffff_fffe);
    queue_req(REQ_INSERT, 32'h7fff_fffe);
    queue_req(REQ_SEARCH, 32'h8000_0001);
    queue_req(REQ_INSERT, 32'd0);
    queue_req(REQ_SEARCH, 32'd0);
    wait_drained();

    run_phase(360, 0, 0, 1'b0);
    run_phase(360, 55, 0, 1'b0);
    run_phase(360, 0, 55, 1'b0);
    run_phase(280, 9, 9, 1'b1);

    // tree filled wherever a key can still land, then traffic on a full tree
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    fill_tree();
    run_phase(120, 9, 9, 1'b0);

    repeat (LEVELS + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
